### rtl/core/kcss_pkg.sv
`default_nettype none
package kcss_pkg;

  localparam int KeyTimeWidth = 32;
  localparam int ValueWidth   = 16;
  localparam int CountWidth   = 6;
  localparam int IndexWidth   = 5;
  localparam int CfgAddrWidth = 2;
  localparam int CfgDataWidth = 6;

  localparam logic [CfgAddrWidth-1:0] CFG_LEVEL_COUNT = 2'd0;
  localparam logic [CfgAddrWidth-1:0] CFG_SPLIT_COUNT = 2'd1;
  localparam logic [CfgAddrWidth-1:0] CFG_STEREO      = 2'd2;

  localparam logic signed [17:0] ValueOne = 18'sd16384;

  typedef struct packed {
    logic                           mode;
    logic                           curve_select;
    logic [IndexWidth-1:0]          key_index;
    logic [KeyTimeWidth-1:0]        key_time;
    logic signed [ValueWidth-1:0]   key_value;
    logic [KeyTimeWidth-1:0]        query_time;
  } item_t;

  typedef struct packed {
    logic                           found;
    logic signed [ValueWidth-1:0]   level;
    logic signed [ValueWidth-1:0]   left_level;
    logic signed [ValueWidth-1:0]   right_level;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_FETCH2,
    ST_DIV,
    ST_MUL,
    ST_NEXT,
    ST_SHARE,
    ST_SHARE2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic fetch;
    logic fetch2;
    logic div_step;
    logic mul;
    logic switch_curve;
    logic share;
    logic share2;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_write;
    logic scan_done;
    logic eval_fail;
    logic need_interp;
    logic div_done;
    logic on_split;
    logic stereo;
  } status_t;

endpackage
`default_nettype wire

### rtl/core/kcss_ctrl.sv
`default_nettype none
module kcss_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             start,
  output logic            busy,
  output kcss_pkg::cmd_t  cmd,
  input  kcss_pkg::status_t sts
);
  import kcss_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_SCAN;
      ST_SCAN: begin
        if (sts.is_write) state_next = ST_IDLE;
        else if (sts.scan_done) state_next = ST_FETCH;
      end
      ST_FETCH:  state_next = ST_FETCH2;
      ST_FETCH2: begin
        if (sts.eval_fail) state_next = ST_DONE;
        else if (sts.need_interp) state_next = ST_DIV;
        else state_next = ST_NEXT;
      end
      ST_DIV:    if (sts.div_done) state_next = ST_MUL;
      ST_MUL:    state_next = ST_NEXT;
      ST_NEXT: begin
        if (sts.on_split) state_next = ST_SHARE;
        else if (sts.stereo) state_next = ST_SCAN;
        else state_next = ST_DONE;
      end
      ST_SHARE:  state_next = ST_SHARE2;
      ST_SHARE2: state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:   begin cmd.load = start; cmd.scan_start = start; end
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_FETCH:  cmd.fetch = 1'b1;
      ST_FETCH2: cmd.fetch2 = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_MUL:    cmd.mul = 1'b1;
      ST_NEXT:   cmd.switch_curve = !sts.on_split && sts.stereo;
      ST_SHARE:  cmd.share = 1'b1;
      ST_SHARE2: cmd.share2 = 1'b1;
      ST_DONE:   cmd.emit = 1'b1;
      default:   cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/kcss_datapath.sv
`default_nettype none
module kcss_datapath #(
  parameter int MAX_KEYS      = 32,
  parameter int FRACTION_BITS = 14
) (
  input  wire                 clk,
  input  wire                 rst,
  input  kcss_pkg::item_t     item,
  input  kcss_pkg::cmd_t      cmd,
  output kcss_pkg::status_t   sts,
  input  wire [kcss_pkg::CountWidth-1:0] level_key_count,
  input  wire [kcss_pkg::CountWidth-1:0] split_key_count,
  input  wire                 stereo_enable,
  output logic                result_valid,
  output kcss_pkg::result_t   result
);
  import kcss_pkg::*;

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int QW = KeyTimeWidth + FRACTION_BITS;
  localparam int DCW = $clog2(QW + 1);

  logic [KeyTimeWidth-1:0] lvl_t [MAX_KEYS];
  logic [ValueWidth-1:0]   lvl_v [MAX_KEYS];
  logic [KeyTimeWidth-1:0] spl_t [MAX_KEYS];
  logic [ValueWidth-1:0]   spl_v [MAX_KEYS];

  item_t                   it;
  logic                    on_split;
  logic [CW-1:0]           n;
  logic [CW-1:0]           i;
  logic [AW-1:0]           idx;
  logic                    below;
  logic                    scan_done;
  logic [KeyTimeWidth-1:0] rd_t;
  logic [ValueWidth-1:0]   rd_v;
  logic signed [ValueWidth-1:0] v0, v1;
  logic                    fail;
  logic [QW-1:0]           quo;
  logic [KeyTimeWidth:0]   rem;
  logic [KeyTimeWidth-1:0] span;
  logic [DCW-1:0]          dcnt;
  logic signed [ValueWidth-1:0] cur;
  logic signed [ValueWidth-1:0] lv;
  logic signed [ValueWidth-1:0] dv;

  logic [CW-1:0] n_sel;
  logic [CountWidth-1:0] cnt_raw;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] last_idx;
  logic [AW-1:0] fetch_idx;
  logic          fetch_ok;
  logic [KeyTimeWidth:0] rem_sh;
  logic signed [ValueWidth:0] diff;
  logic signed [ValueWidth+FRACTION_BITS+1:0] prod;
  logic signed [ValueWidth-1:0] interp_v;
  logic signed [17:0] lf, rf, dx2, rx2;
  logic signed [33:0] pl, pr;

  // Scan compare uses the registered beat read from the previous address i, kept in i_prev.
  logic [CW-1:0] i_prev;
  logic          scan_live;
  logic          stop, stopped;

  // Next key time and value are read at fetch: fetch reads fetch_idx, the side port fetch_idx+1.
  logic [KeyTimeWidth-1:0] t1_r;
  logic [ValueWidth-1:0]   v1_r;

  assign cnt_raw = cmd.switch_curve ? split_key_count : level_key_count;
  always_comb begin
    if (32'(cnt_raw) > 32'(MAX_KEYS))
      n_sel = CW'(MAX_KEYS);
    else
      n_sel = CW'(cnt_raw);
  end

  assign last_idx = AW'(n - 1'b1);
  assign rd_addr  = cmd.scan_step ? AW'(i) : (cmd.fetch ? fetch_idx : AW'(fetch_idx + 1'b1));
  always_comb begin
    fetch_idx = below ? idx : last_idx;
    fetch_ok  = below || (on_split && n != '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !item.mode && (32'(item.key_index) < 32'(MAX_KEYS))) begin
      if (!item.curve_select) begin
        lvl_t[AW'(item.key_index)] <= item.key_time;
        lvl_v[AW'(item.key_index)] <= item.key_value;
      end else begin
        spl_t[AW'(item.key_index)] <= item.key_time;
        spl_v[AW'(item.key_index)] <= item.key_value;
      end
    end
    rd_t <= on_split ? spl_t[rd_addr] : lvl_t[rd_addr];
    rd_v <= on_split ? spl_v[rd_addr] : lvl_v[rd_addr];
  end

  assign stop = stopped || !(it.query_time > rd_t);

  assign rem_sh = {rem[KeyTimeWidth-1:0], quo[QW-1]};
  assign diff = {v1[ValueWidth-1], v1} - {v0[ValueWidth-1], v0};
  assign dx2 = 18'(dv) <<< 1;
  assign rx2 = (ValueOne - 18'(dv)) <<< 1;
  assign lf = dx2[17] ? 18'sd0 : (dx2 > ValueOne ? ValueOne : dx2);
  assign rf = rx2[17] ? 18'sd0 : (rx2 > ValueOne ? ValueOne : rx2);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
    if (cmd.load) begin
      it       <= item;
      on_split <= 1'b0;
    end
    if (cmd.load || cmd.switch_curve) begin
      i         <= '0;
      idx       <= '0;
      below     <= 1'b0;
      scan_done <= 1'b0;
      fail      <= 1'b0;
      scan_live <= 1'b0;
      stopped   <= 1'b0;
      if (cmd.switch_curve) begin
        on_split <= 1'b1;
        lv       <= cur;
      end
    end
    if (cmd.scan_start || cmd.switch_curve) begin
      n <= n_sel;
    end
    if (cmd.scan_step) begin
      scan_live <= !scan_done && (i < n);
      i_prev    <= i;
      if (scan_live && !stop) begin
        idx   <= AW'(i_prev);
        below <= 1'b1;
      end
      if (scan_live && stop) begin
        stopped <= 1'b1;
      end
      if (!scan_done) begin
        if (i >= n) begin
          scan_done <= 1'b1;
        end else begin
          i <= i + 1'b1;
        end
      end
    end
    if (cmd.fetch2) begin
      v0 <= rd_v;
      cur <= rd_v;
      fail <= !fetch_ok || (it.query_time < rd_t);
      span <= t1_r - rd_t;
      quo <= {it.query_time - rd_t, FRACTION_BITS'(0)};
      rem <= '0;
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, span}) begin
        rem <= rem_sh - {1'b0, span};
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[QW-2:0], 1'b0};
      end
      dcnt <= dcnt + 1'b1;
    end
    if (cmd.mul) begin
      cur <= interp_v;
    end
    if (cmd.share) begin
      dv <= cur;
    end
    if (cmd.share2) begin
      pl    <= 34'(lv) * 34'(lf);
      pr    <= 34'(lv) * 34'(rf);
    end
    if (cmd.emit) begin
      result.found <= !fail;
      if (fail) begin
        result.level <= '0;
        result.left_level <= '0;
        result.right_level <= '0;
      end else if (on_split) begin
        result.level <= lv;
        result.left_level <= ValueWidth'(pl >>> 14);
        result.right_level <= ValueWidth'(pr >>> 14);
      end else begin
        result.level <= cur;
        result.left_level <= cur;
        result.right_level <= cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      t1_r <= on_split ? spl_t[AW'(fetch_idx + 1'b1)] : lvl_t[AW'(fetch_idx + 1'b1)];
      v1_r <= on_split ? spl_v[AW'(fetch_idx + 1'b1)] : lvl_v[AW'(fetch_idx + 1'b1)];
    end
  end
  assign v1 = v1_r;

  assign prod = (ValueWidth+FRACTION_BITS+2)'(diff) *
                $signed({1'b0, quo[FRACTION_BITS:0]});
  assign interp_v = ValueWidth'(v0 + ValueWidth'(prod >>> FRACTION_BITS));

  assign sts.is_write    = !it.mode;
  assign sts.scan_done   = scan_done && !scan_live;
  assign sts.eval_fail   = !fetch_ok || (it.query_time < rd_t);
  assign sts.need_interp = (32'(fetch_idx) + 1 < 32'(n)) && (rd_t < t1_r);
  assign sts.div_done    = (dcnt == DCW'(QW - 1));
  assign sts.on_split    = on_split;
  assign sts.stereo      = stereo_enable;

endmodule
`default_nettype wire

### rtl/core/keyframe_curve_stereo_split.sv
`default_nettype none
// A write item keeps busy high for one cycle. A query evaluates the level curve and, in stereo
// mode, the distribution curve; each curve scans its n keys (one key per cycle) and may
// interpolate through the 46-step bit-serial divider; ST_DONE ends the query, after ST_SHARE
// and ST_SHARE2 in stereo.
// done follows the last busy cycle for one cycle and cannot be stalled by the receiver.
// Synchronous reset clears control, strobe and configuration; key tables stay undefined.
module keyframe_curve_stereo_split #(
  parameter int MAX_KEYS      = 32,
  parameter int FRACTION_BITS = 14
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  output logic                    busy,
  input  kcss_pkg::item_t         item,
  output logic                    done,
  output kcss_pkg::result_t       result,
  input  wire                     cfg_we,
  input  wire [kcss_pkg::CfgAddrWidth-1:0] cfg_index,
  input  wire [kcss_pkg::CfgDataWidth-1:0] cfg_data
);
  import kcss_pkg::*;

  cmd_t    cmd;
  status_t sts;
  logic [CountWidth-1:0] level_key_count, split_key_count;
  logic stereo_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_key_count <= '0;
      split_key_count <= '0;
      stereo_enable   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEVEL_COUNT: level_key_count <= cfg_data;
        CFG_SPLIT_COUNT: split_key_count <= cfg_data;
        CFG_STEREO:      stereo_enable   <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  kcss_ctrl u_ctrl (
    .clk (clk), .rst (rst), .start (start), .busy (busy), .cmd (cmd), .sts (sts)
  );

  kcss_datapath #(.MAX_KEYS(MAX_KEYS), .FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk (clk), .rst (rst), .item (item), .cmd (cmd), .sts (sts),
    .level_key_count (level_key_count), .split_key_count (split_key_count),
    .stereo_enable (stereo_enable), .result_valid (done), .result (result)
  );

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without work");
  a_no_done_on_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done) else $error("result too early");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |-> (result.level == '0)) else $error("level not cleared");

endmodule
`default_nettype wire
